FILE: design/push_button_gesture_classifier_top_defines.svh
// Assertion macros used by the gesture classifier top level.
`ifndef PUSH_BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define PUSH_BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define PBGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PBGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBGC_ASSERT(lbl, prop, msg)
`define PBGC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/pbgc_pkg.sv
// Types and constants of the push-button gesture classifier.
`default_nettype none
package pbgc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int REP_W  = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] CLICK_RST  = 16'd350;
  localparam logic [CFG_W-1:0] LONG_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RST = 16'd200;

  localparam logic [REP_W-1:0]  REP_MAX    = 16'hFFFF;
  localparam logic [TIME_W-1:0] QUO_SAT    = 32'd65534;

  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_CLICK  = 2'd0,
    REG_LONG   = 2'd1,
    REG_REPEAT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_DOWN         = 3'd0,
    EV_UP           = 3'd1,
    EV_CLICK        = 3'd2,
    EV_LONG_CLICK   = 3'd3,
    EV_HOLD_START   = 3'd4,
    EV_HOLD_REPEAT  = 3'd5,
    EV_HOLD_RELEASE = 3'd6
  } evt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: design/pbgc_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module pbgc_div
  import pbgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [CFG_W-1:0]  divisor,
  output logic      [TIME_W-1:0] quotient,
  output div_stat_t              stat
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]    quo_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     dsr_r;

  logic [CFG_W:0]   trial;
  logic             step_bit;
  logic [CFG_W-1:0] step_rem;
  logic [CFG_W:0]   diff;

  // remainder stays below the divisor, so the borrow bit is the compare
  always_comb begin
    trial    = {rem_r, quo_r[TIME_W-1]};
    diff     = trial - {1'b0, dsr_r};
    step_bit = !diff[CFG_W];
    step_rem = step_bit ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[TIME_W-2:0], step_bit};
      rem_r <= step_rem;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

FILE: design/push_button_gesture_classifier_top.sv
// Top level of the push-button gesture classifier.
// Input channel in_valid/in_stall: one word is in_op (press, release, tick)
//   and in_time_ms, the wrapping millisecond stamp.
// Result channel out_valid/out_stall: 0, 1 or 2 words per input word, each
//   out_event_code, out_repeat_count, out_held_ms and out_last (final word).
// APB port: click time at 0x0, long-press time at 0x4, repeat period at 0x8,
//   16 bits each; pready tied high; write only while the block is idle.
// Sequence after an accepted word (states S_EVAL, S_DIV, S_EMIT):
//   press or release with results: S_EVAL, then S_EMIT loads the output
//   register once the slot is free, then S_IDLE takes the next word.
//   tick past the long-press time: S_EVAL starts the serial divide, S_DIV
//   waits for it, then S_EMIT if the count changed, else S_IDLE.
//   word with no results: S_EVAL goes straight back to S_IDLE.
// One word is in flight at a time; in_stall stays high until its results
//   are in the output stage.
// Stall: a second result word waits in a pending slot behind the output
//   register; nothing new loads until both are gone, payload held steady.
// Reset: rst_n (synchronous) releases the button, clears the repeat count
//   and hold flag and restores 350, 1000 and 200 ms.
`default_nettype none
`include "push_button_gesture_classifier_top_defines.svh"
module push_button_gesture_classifier_top
  import pbgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [TIME_W-1:0] in_time_ms,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_event_code,
  output logic [REP_W-1:0]       out_repeat_count,
  output logic [TIME_W-1:0]      out_held_ms,
  output logic                   out_last,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // configuration registers
  logic [CFG_W-1:0] click_r, long_r, repeat_r;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_r  <= CLICK_RST;
      long_r   <= LONG_RST;
      repeat_r <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_CLICK:  click_r  <= pwdata[CFG_W-1:0];
        REG_LONG:   long_r   <= pwdata[CFG_W-1:0];
        REG_REPEAT: repeat_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CLICK:  prdata = {{(DATA_W-CFG_W){1'b0}}, click_r};
      REG_LONG:   prdata = {{(DATA_W-CFG_W){1'b0}}, long_r};
      REG_REPEAT: prdata = {{(DATA_W-CFG_W){1'b0}}, repeat_r};
      default:    prdata = '0;
    endcase
  end

  // button state
  logic [TIME_W-1:0] start_r;
  logic              active_r;
  logic [REP_W-1:0]  reps_r;
  logic              hold_r;

  // captured input word
  logic [1:0]        op_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] held_r;

  // staged result codes
  evt_t code0_r, code1_r;
  logic two_r;

  // output register and pending slot
  logic              out_valid_r;
  evt_t              out_code_r;
  logic [REP_W-1:0]  out_reps_r;
  logic [TIME_W-1:0] out_held_r;
  logic              out_last_r;
  logic              pend_valid_r;
  evt_t              pend_code_r;

  state_t state_r, state_nxt;

  logic in_acc, out_acc;
  logic slot_free, emit_load;
  logic div_start;
  logic tick_hit;
  logic rel_click, rel_long;

  logic [TIME_W-1:0] div_quo;
  div_stat_t         div_stat;
  logic              div_run;
  logic [TIME_W-1:0] div_dividend;
  logic [REP_W-1:0]  cnt_calc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign slot_free = !pend_valid_r && (!out_valid_r || out_acc);

  assign tick_hit     = active_r && (repeat_r != '0) &&
                        (held_r >= {{(TIME_W-CFG_W){1'b0}}, long_r});
  assign div_dividend = held_r - {{(TIME_W-CFG_W){1'b0}}, long_r};
  assign rel_click    = held_r < {{(TIME_W-CFG_W){1'b0}}, click_r};
  assign rel_long     = held_r < {{(TIME_W-CFG_W){1'b0}}, long_r};

  // 1 + quotient, saturated to the counter range
  assign cnt_calc = (div_quo >= QUO_SAT) ? REP_MAX : (div_quo[REP_W-1:0] + 1'b1);

  assign div_run = div_stat.busy || div_stat.done;

  pbgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (repeat_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (op_r)
          OP_PRESS: state_nxt = S_EMIT;
          OP_RELEASE: state_nxt = active_r ? S_EMIT : S_IDLE;
          OP_TICK: begin
            if (tick_hit) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_stat.done) state_nxt = (cnt_calc != reps_r) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // button state, control part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      reps_r   <= '0;
      hold_r   <= 1'b0;
      start_r  <= '0;
    end else begin
      if (state_r == S_EVAL) begin
        case (op_r)
          OP_PRESS: begin
            start_r  <= time_r;
            active_r <= 1'b1;
            reps_r   <= '0;
            hold_r   <= 1'b0;
          end
          OP_RELEASE: active_r <= 1'b0;
          default: ;
        endcase
      end else if (state_r == S_DIV && div_stat.done && cnt_calc != reps_r) begin
        reps_r <= cnt_calc;
        hold_r <= 1'b1;
      end
    end
  end

  // capture and staging
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      time_r <= in_time_ms;
      held_r <= in_time_ms - start_r;
    end else if (state_r == S_EVAL && op_r == OP_PRESS) begin
      held_r <= '0;
    end
    if (state_r == S_EVAL) begin
      code1_r <= EV_UP;
      if (op_r == OP_PRESS) begin
        code0_r <= EV_DOWN;
        two_r   <= 1'b0;
      end else if (rel_click) begin
        code0_r <= EV_CLICK;
        two_r   <= 1'b1;
      end else if (rel_long) begin
        code0_r <= EV_LONG_CLICK;
        two_r   <= 1'b1;
      end else if (hold_r) begin
        code0_r <= EV_HOLD_RELEASE;
        two_r   <= 1'b1;
      end else begin
        code0_r <= EV_UP;
        two_r   <= 1'b0;
      end
    end else if (state_r == S_DIV && div_stat.done) begin
      code0_r <= EV_HOLD_REPEAT;
      code1_r <= EV_HOLD_START;
      two_r   <= (cnt_calc == REP_W'(1));
    end
  end

  // output stage, control part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= two_r;
    end else if (out_acc) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  // output stage, payload; both words of one input share count and held time
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_code_r  <= code0_r;
      out_reps_r  <= reps_r;
      out_held_r  <= held_r;
      out_last_r  <= !two_r;
      pend_code_r <= code1_r;
    end else if (out_acc && pend_valid_r) begin
      out_code_r <= pend_code_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_code_r;
  assign out_repeat_count = out_reps_r;
  assign out_held_ms      = out_held_r;
  assign out_last         = out_last_r;

  `PBGC_ASSERT(a_pend_behind_out, pend_valid_r |-> out_valid_r, "pending word alone")
  `PBGC_ASSERT(a_nonlast_has_pend, (out_valid_r && !out_last_r) |-> pend_valid_r, "pend missing")
  `PBGC_ASSERT(a_accept_eval, in_acc |=> (state_r == S_EVAL), "accepted word not evaluated")
  `PBGC_ASSERT(a_div_owned, div_run |-> (state_r == S_DIV), "divider outside S_DIV")
  `PBGC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "reset busy")

endmodule
`default_nettype wire
